[hdl/pmn31_pkg.sv]
// Shared constants, types and field arithmetic modulo 2^31-1.
// Used by pmn31_front, pmn31_back and the top level.
`default_nettype none
package pmn31_pkg;

    localparam int unsigned FE_W    = 31;
    localparam logic [FE_W-1:0] FIELD_P = 31'h7FFF_FFFF;
    localparam logic [FE_W-1:0] INV_EXP = FIELD_P - 31'd2;
    localparam int unsigned N_IN    = 12;
    localparam int unsigned IN_W    = 376;
    localparam int unsigned OUT_W   = 96;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef logic [FE_W-1:0] fe_t;
    typedef fe_t [N_IN-1:0] triple_t;

    function automatic fe_t fe_red(input fe_t v);
        return (v == FIELD_P) ? '0 : v;
    endfunction

    function automatic fe_t fe_add(input fe_t a, input fe_t b);
        logic [FE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, FIELD_P})
        begin
            s = s - {1'b0, FIELD_P};
        end
        return s[FE_W-1:0];
    endfunction

    function automatic fe_t fe_sub(input fe_t a, input fe_t b);
        logic [FE_W:0] s;
        s = {1'b0, a} + {1'b0, FIELD_P} - {1'b0, b};
        if (a >= b)
        begin
            s = {1'b0, a} - {1'b0, b};
        end
        return s[FE_W-1:0];
    endfunction

    function automatic fe_t fe_mul(input fe_t a, input fe_t b);
        logic [2*FE_W-1:0] m;
        logic [FE_W:0]     t;
        logic [FE_W:0]     u;
        m = {{FE_W{1'b0}}, a} * {{FE_W{1'b0}}, b};
        t = {1'b0, m[FE_W-1:0]} + {1'b0, m[2*FE_W-1:FE_W]};
        u = {1'b0, t[FE_W-1:0]} + {{FE_W{1'b0}}, t[FE_W]};
        if (u >= {1'b0, FIELD_P})
        begin
            u = u - {1'b0, FIELD_P};
        end
        return u[FE_W-1:0];
    endfunction

endpackage
`default_nettype wire

[hdl/pmn31_front.sv]
// Input side: accept beats, reduce coordinates, hold them in a two-entry queue.
// Depends on pmn31_pkg.
`default_nettype none
module pmn31_front
    import pmn31_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire triple_t       in_data,
    output logic               q_valid,
    input  wire logic          q_ready,
    output triple_t            q_data
);

    triple_t     mem_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;
    triple_t     red;

    always_comb
    begin
        for (int i = 0; i < N_IN; i++)
        begin
            red[i] = fe_red(in_data[i]);
        end
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= red;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |=> count_reg == 2'd2)
        else $error("queue overfilled");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree when empty");

endmodule
`default_nettype wire

[hdl/pmn31_back.sv]
// Arithmetic pipeline: minors, normal, validity, Fermat inverse, scaling.
// Depends on pmn31_pkg.
`default_nettype none
module pmn31_back
    import pmn31_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    q_valid,
    output logic         q_ready,
    input  wire triple_t q_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output logic         out_flag,
    output fe_t          out_b,
    output fe_t          out_c,
    output fe_t          out_d
);

    localparam int unsigned NI = FE_W;
    localparam int unsigned NS = 5 + NI + 2;

    logic [NS-1:0] v_reg;
    logic          en;

    fe_t x1_reg [4];
    fe_t p1_reg [12];
    fe_t x2_reg [4];
    fe_t m2_reg [6];
    fe_t t3_reg [12];
    fe_t n4_reg [4];
    fe_t n5_reg [4];
    logic ok5_reg;

    fe_t  acc_reg [NI+1];
    fe_t  base_reg [NI+1];
    fe_t  s1_reg [NI+1];
    fe_t  s2_reg [NI+1];
    fe_t  s3_reg [NI+1];
    logic ok_reg [NI+1];

    logic ok_o_reg;
    fe_t  b_o_reg, c_o_reg, d_o_reg;

    fe_t  sum5;
    logic ok5_next;

    assign en      = !v_reg[NS-1] || out_ready;
    assign q_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], q_valid};
        end
    end

    always_comb
    begin
        sum5 = fe_add(fe_add(n4_reg[0], n4_reg[1]), fe_add(n4_reg[2], n4_reg[3]));
        ok5_next = (n4_reg[0] != '0) && (n4_reg[1] != '0) && (n4_reg[2] != '0)
                   && (n4_reg[3] != '0) && (sum5 != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                x1_reg[i] <= q_data[i];
                x2_reg[i] <= x1_reg[i];
            end
            p1_reg[0]  <= fe_mul(q_data[6], q_data[11]);
            p1_reg[1]  <= fe_mul(q_data[7], q_data[10]);
            p1_reg[2]  <= fe_mul(q_data[5], q_data[11]);
            p1_reg[3]  <= fe_mul(q_data[7], q_data[9]);
            p1_reg[4]  <= fe_mul(q_data[5], q_data[10]);
            p1_reg[5]  <= fe_mul(q_data[6], q_data[9]);
            p1_reg[6]  <= fe_mul(q_data[4], q_data[11]);
            p1_reg[7]  <= fe_mul(q_data[7], q_data[8]);
            p1_reg[8]  <= fe_mul(q_data[4], q_data[10]);
            p1_reg[9]  <= fe_mul(q_data[6], q_data[8]);
            p1_reg[10] <= fe_mul(q_data[4], q_data[9]);
            p1_reg[11] <= fe_mul(q_data[5], q_data[8]);
            for (int q = 0; q < 6; q++)
            begin
                m2_reg[q] <= fe_sub(p1_reg[2*q], p1_reg[2*q+1]);
            end
            // minors: 0 cd, 1 bd, 2 bc, 3 ad, 4 ac, 5 ab
            t3_reg[0]  <= fe_mul(x2_reg[1], m2_reg[0]);
            t3_reg[1]  <= fe_mul(x2_reg[2], m2_reg[1]);
            t3_reg[2]  <= fe_mul(x2_reg[3], m2_reg[2]);
            t3_reg[3]  <= fe_mul(x2_reg[0], m2_reg[0]);
            t3_reg[4]  <= fe_mul(x2_reg[2], m2_reg[3]);
            t3_reg[5]  <= fe_mul(x2_reg[3], m2_reg[4]);
            t3_reg[6]  <= fe_mul(x2_reg[0], m2_reg[1]);
            t3_reg[7]  <= fe_mul(x2_reg[1], m2_reg[3]);
            t3_reg[8]  <= fe_mul(x2_reg[3], m2_reg[5]);
            t3_reg[9]  <= fe_mul(x2_reg[0], m2_reg[2]);
            t3_reg[10] <= fe_mul(x2_reg[1], m2_reg[4]);
            t3_reg[11] <= fe_mul(x2_reg[2], m2_reg[5]);
            n4_reg[0] <= fe_add(fe_sub(t3_reg[0], t3_reg[1]), t3_reg[2]);
            n4_reg[1] <= fe_sub(fe_sub(t3_reg[4], t3_reg[3]), t3_reg[5]);
            n4_reg[2] <= fe_add(fe_sub(t3_reg[6], t3_reg[7]), t3_reg[8]);
            n4_reg[3] <= fe_sub(fe_sub(t3_reg[10], t3_reg[9]), t3_reg[11]);
            for (int i = 0; i < 4; i++)
            begin
                n5_reg[i] <= ok5_next ? n4_reg[i] : '0;
            end
            ok5_reg <= ok5_next;
            acc_reg[0]  <= 31'd1;
            base_reg[0] <= n5_reg[0];
            s1_reg[0]   <= n5_reg[1];
            s2_reg[0]   <= n5_reg[2];
            s3_reg[0]   <= n5_reg[3];
            ok_reg[0]   <= ok5_reg;
            ok_o_reg <= ok_reg[NI];
            b_o_reg  <= fe_mul(s1_reg[NI], acc_reg[NI]);
            c_o_reg  <= fe_mul(s2_reg[NI], acc_reg[NI]);
            d_o_reg  <= fe_mul(s3_reg[NI], acc_reg[NI]);
        end
    end

    for (genvar k = 0; k < NI; k++)
    begin : g_inv
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k+1]  <= INV_EXP[k] ? fe_mul(acc_reg[k], base_reg[k]) : acc_reg[k];
                base_reg[k+1] <= fe_mul(base_reg[k], base_reg[k]);
                s1_reg[k+1]   <= s1_reg[k];
                s2_reg[k+1]   <= s2_reg[k];
                s3_reg[k+1]   <= s3_reg[k];
                ok_reg[k+1]   <= ok_reg[k];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_flag  = ok_o_reg;
    assign out_b     = b_o_reg;
    assign out_c     = c_o_reg;
    assign out_d     = d_o_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_flag) |-> (out_b == '0 && out_c == '0 && out_d == '0))
        else $error("invalid normal with nonzero coordinates");
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_b != FIELD_P && out_c != FIELD_P && out_d != FIELD_P))
        else $error("unreduced result");
    a_no_pull_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !q_ready)
        else $error("pipeline advanced under stall");

endmodule
`default_nettype wire

[hdl/projective_normal_mod_mersenne31_unit.sv]
// channel | dir | handshake               | payload
// s_axis  | in  | s_axis_tvalid/tready    | tdata: 12 coordinates, 31 bits each
// m_axis  | out | m_axis_tvalid/tready    | tdata: norm_b..d; tuser: normal_valid
// One item per cycle sustained while m_axis_tready is high; an input beat passes the
// queue, then 38 back stages that hold the 31-step Fermat inverse chain.
// A two-entry queue behind the input keeps s_axis_tready free of a combinational path from m_axis_tready.
// An output stall freezes the whole back pipeline; reset clears valids, queue count and pointers, not data.
// Depends on pmn31_pkg, pmn31_front, pmn31_back.
`default_nettype none
module projective_normal_mod_mersenne31_unit
    import pmn31_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // row0_a,row0_b,row0_c,row0_d,row1_a..row1_d,row2_a..row2_d, zero pad
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // norm_b, norm_c, norm_d, zero pad
    output logic [OUT_W-1:0]      m_axis_tdata,
    // normal_valid
    output logic                  m_axis_tuser
);

    triple_t in_data, q_data;
    logic    q_valid, q_ready;
    fe_t     nb, nc, nd;

    assign in_data = s_axis_tdata[N_IN*FE_W-1:0];

    pmn31_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    pmn31_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_flag  (m_axis_tuser),
        .out_b     (nb),
        .out_c     (nc),
        .out_d     (nd)
    );

    assign m_axis_tdata = {3'b000, nd, nc, nb};

endmodule
`default_nettype wire

[dv/projective_normal_mod_mersenne31_unit_tb.sv]
// Self-checking bench for projective_normal_mod_mersenne31_unit: random and corner triples,
// expected normals predicted in the bench, compared beat by beat. Depends on pmn31_pkg.
`timescale 1ns / 1ps
module projective_normal_mod_mersenne31_unit_tb;
    import pmn31_pkg::*;

    localparam int unsigned N_RANDOM = 1600;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam logic [30:0] MOD_P = 31'h7FFF_FFFF;

    typedef struct packed {
        logic        ok;
        logic [30:0] nb;
        logic [30:0] nc;
        logic [30:0] nd;
    } normal_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    logic [IN_W-1:0] triple_q[$];
    normal_t normal_q[$];
    int unsigned errors;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned valid_seen;
    int unsigned idle_cycles;
    int unsigned send_gap;
    int unsigned recv_gap;
    logic drain_hold;
    logic in_taken;
    logic out_taken;

    projective_normal_mod_mersenne31_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #10 clk = ~clk;

    function automatic logic [30:0] gf_mul(input logic [30:0] a, input logic [30:0] b);
        logic [63:0] m;
        m = 64'(a) * 64'(b);
        return 31'(m % 64'(MOD_P));
    endfunction

    function automatic logic [30:0] gf_add(input logic [30:0] a, input logic [30:0] b);
        return 31'((32'(a) + 32'(b)) % 32'(MOD_P));
    endfunction

    function automatic logic [30:0] gf_sub(input logic [30:0] a, input logic [30:0] b);
        return 31'((32'(a) + 32'(MOD_P) - 32'(b)) % 32'(MOD_P));
    endfunction

    function automatic logic [30:0] gf_inv(input logic [30:0] a);
        logic [30:0] acc;
        logic [30:0] base;
        logic [30:0] e;
        acc = 31'd1;
        base = a;
        e = MOD_P - 31'd2;
        while (e != 0)
        begin
            if (e[0])
                acc = gf_mul(acc, base);
            base = gf_mul(base, base);
            e = e >> 1;
        end
        return acc;
    endfunction

    // minor over the three columns ca, cb, cc
    function automatic logic [30:0] minor3(input logic [30:0] v[3][4],
                                          input int ca, input int cb, input int cc);
        logic [30:0] pos;
        logic [30:0] neg;
        pos = gf_add(gf_add(gf_mul(v[0][ca], gf_mul(v[1][cb], v[2][cc])),
                            gf_mul(v[0][cb], gf_mul(v[1][cc], v[2][ca]))),
                     gf_mul(v[0][cc], gf_mul(v[1][ca], v[2][cb])));
        neg = gf_add(gf_add(gf_mul(v[0][cc], gf_mul(v[1][cb], v[2][ca])),
                            gf_mul(v[0][cb], gf_mul(v[1][ca], v[2][cc]))),
                     gf_mul(v[0][ca], gf_mul(v[1][cc], v[2][cb])));
        return gf_sub(pos, neg);
    endfunction

    function automatic normal_t predict_normal(input logic [IN_W-1:0] d);
        logic [30:0] v[3][4];
        logic [30:0] n0;
        logic [30:0] n1;
        logic [30:0] n2;
        logic [30:0] n3;
        logic [30:0] inv;
        normal_t r;
        for (int k = 0; k < 12; k++)
        begin
            v[k/4][k%4] = d[k*31 +: 31];
            if (v[k/4][k%4] == MOD_P)
                v[k/4][k%4] = '0;
        end
        n0 = minor3(v, 1, 2, 3);
        n1 = gf_sub(31'd0, minor3(v, 0, 2, 3));
        n2 = minor3(v, 0, 1, 3);
        n3 = gf_sub(31'd0, minor3(v, 0, 1, 2));
        r = '0;
        if (n0 != 0 && n1 != 0 && n2 != 0 && n3 != 0
            && gf_add(gf_add(n0, n1), gf_add(n2, n3)) != 0)
        begin
            inv = gf_inv(n0);
            r.ok = 1'b1;
            r.nb = gf_mul(n1, inv);
            r.nc = gf_mul(n2, inv);
            r.nd = gf_mul(n3, inv);
        end
        return r;
    endfunction

    function automatic logic [30:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 31'd0;
            1: return MOD_P;
            2: return MOD_P - 31'd1;
            3: return 31'($urandom_range(1, 3));
            default: return 31'($urandom_range(0, 32'h7FFF_FFFE));
        endcase
    endfunction

    function automatic logic [IN_W-1:0] pack_triple(input logic [30:0] c[12]);
        logic [IN_W-1:0] d;
        d = '0;
        for (int k = 0; k < 12; k++)
            d[k*31 +: 31] = c[k];
        return d;
    endfunction

    task automatic add_triple(input logic [30:0] c[12]);
        triple_q = {triple_q, pack_triple(c)};
    endtask

    // beats taken at the last rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            out_taken <= 1'b0;
        end
        else
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            out_taken <= m_axis_tvalid && m_axis_tready;
        end
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_gap <= 0;
        end
        else if (s_axis_tvalid && !in_taken)
        begin
        end
        else if (send_gap != 0)
        begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end
        else if (triple_q.size() != 0 && !(drain_hold && normal_q.size() != 0))
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= triple_q.pop_front();
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // receiver stall
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end
        else if (recv_gap != 0)
        begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (out_taken)
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        normal_t got;
        normal_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_axis_tvalid && s_axis_tready)
            begin
                normal_q = {normal_q, predict_normal(s_axis_tdata)};
                beats_in <= beats_in + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                beats_out <= beats_out + 1;
                got.ok = m_axis_tuser;
                got.nb = m_axis_tdata[30:0];
                got.nc = m_axis_tdata[61:31];
                got.nd = m_axis_tdata[92:62];
                if (normal_q.size() == 0)
                begin
                    $display("%0t: unexpected beat %h", $time, got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = normal_q.pop_front();
                    if (got.ok) valid_seen <= valid_seen + 1;
                    if (got !== want)
                    begin
                        $display("%0t: expected ok=%0d b=%h c=%h d=%h got ok=%0d b=%h c=%h d=%h",
                                 $time, want.ok, want.nb, want.nc, want.nd,
                                 got.ok, got.nb, got.nc, got.nd);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d beats outstanding", normal_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [30:0] c[12];
        clk = 1'b0;
        rst_n = 1'b0;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        valid_seen = 0;
        idle_cycles = 0;
        drain_hold = 1'b0;

        // all zero, all P, all P-1, identity-like rows, coordinates 1..12
        foreach (c[k]) c[k] = 31'd0;
        add_triple(c);
        foreach (c[k]) c[k] = MOD_P;
        add_triple(c);
        foreach (c[k]) c[k] = MOD_P - 31'd1;
        add_triple(c);
        foreach (c[k]) c[k] = (k % 5 == 0) ? 31'd1 : 31'd0;
        add_triple(c);
        foreach (c[k]) c[k] = 31'(k + 1);
        add_triple(c);
        // generic well-conditioned rows, and the same with an unreduced P substituted, then banded rows
        c = '{31'd1, 31'd2, 31'd3, 31'd5, 31'd7, 31'd11, 31'd13, 31'd17,
              31'd19, 31'd23, 31'd29, 31'd31};
        add_triple(c);
        c[3] = MOD_P;
        add_triple(c);
        c = '{31'd1, 31'd1, 31'd0, 31'd0, 31'd0, 31'd1, 31'd1, 31'd0,
              31'd0, 31'd0, 31'd1, 31'd1};
        add_triple(c);
        // unit-block rows with last column (1,1,1), then (2,3,P-5), then two alternating bit patterns
        c = '{31'd1, 31'd0, 31'd0, 31'd1, 31'd0, 31'd1, 31'd0, 31'd1,
              31'd0, 31'd0, 31'd1, 31'd1};
        add_triple(c);
        c = '{31'd1, 31'd0, 31'd0, 31'd2, 31'd0, 31'd1, 31'd0, 31'd3,
              31'd0, 31'd0, 31'd1, MOD_P - 31'd5};
        add_triple(c);
        foreach (c[k]) c[k] = 31'h2AAA_AAAA ^ 31'(k);
        add_triple(c);
        foreach (c[k]) c[k] = 31'h5555_5555 ^ 31'(k);
        add_triple(c);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // let the pipeline drain once partway
            if (n == N_RANDOM / 2)
            begin
                wait (triple_q.size() == 0 && !s_axis_tvalid);
                drain_hold = 1'b1;
            end
            foreach (c[k]) c[k] = ($urandom_range(0, 3) == 0) ? rand_coord()
                                  : 31'($urandom_range(0, 32'h7FFF_FFFE));
            add_triple(c);
            if (n == N_RANDOM / 2)
            begin
                wait (normal_q.size() == 0);
                drain_hold = 1'b0;
            end
        end

        wait (triple_q.size() == 0 && !s_axis_tvalid);
        wait (normal_q.size() == 0);
        repeat (60) @(posedge clk);
        $display("sent %0d triples, checked %0d normals, %0d of them valid",
                 beats_in, beats_out, valid_seen);
        if (errors == 0 && normal_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

[filelist.f]
hdl/pmn31_pkg.sv
hdl/pmn31_front.sv
hdl/pmn31_back.sv
hdl/projective_normal_mod_mersenne31_unit.sv
dv/projective_normal_mod_mersenne31_unit_tb.sv
